### rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, byte-class constants and the lead byte decoder of the
// UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Default depth of the queue between the decode front and the output back.
  localparam int UTF8D_QUEUE_DEPTH = 4;

  localparam int CP_W = 21;

  // Byte class masks and patterns.
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_PAT  = 8'hf0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_PAT  = 8'he0;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_PAT  = 8'hc0;
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_PAT   = 8'h80;

  // Payload bit masks of lead bytes.
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] LEAD3_BITS = 8'h0f;
  localparam logic [7:0] LEAD2_BITS = 8'h1f;

  // One result item.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            code_valid;
    logic            is_error;
    logic            run_last;
    logic            string_end;
    logic            string_valid;
  } res_t;

  // All results caused by one input byte; r0 goes out first.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } evt_t;

  // Outcome of taking a byte as a lead.
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] cp;
    logic            vld;
    logic            err;
    logic            start;
    logic [1:0]      exp;
    logic [CP_W-1:0] acc;
  } lead_t;

  // Classify a lead byte: ASCII and invalid leads give a result at once,
  // multi-byte leads open a sequence.
  function automatic lead_t lead_decode(logic [7:0] b);
    lead_t l;
    l = '0;
    if ((b & ASCII_MASK) == 8'h00) begin
      l.emit = 1'b1;
      l.cp   = CP_W'(b);
      l.vld  = 1'b1;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      l.start = 1'b1;
      l.exp   = 2'd3;
      l.acc   = CP_W'(b & LEAD4_BITS);
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      l.start = 1'b1;
      l.exp   = 2'd2;
      l.acc   = CP_W'(b & LEAD3_BITS);
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      l.start = 1'b1;
      l.exp   = 2'd1;
      l.acc   = CP_W'(b & LEAD2_BITS);
    end else begin
      l.emit = 1'b1;
      l.err  = 1'b1;
    end
    return l;
  endfunction

endpackage

### rtl/utf8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, runs the UTF-8 sequence state and packs the zero, one or
// two results of each byte into one queue entry.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_utf8_mode,
  input  logic              in_valid,
  input  logic [7:0]        in_byte_in,
  input  logic              in_end_of_string,
  input  logic              q_full,
  output logic              q_push,
  output utf8d_pkg::evt_t   q_wdata
);
  import utf8d_pkg::*;

  logic            mode_r;
  logic [1:0]      exp_r, exp_nxt;
  logic [1:0]      rcv_r, rcv_nxt;
  logic [1:0]      skip_r, skip_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            ok_r, ok_nxt;

  logic            accept;
  lead_t           lead;
  logic [2:0]      k;
  logic [2:0]      n3;
  logic [CP_W-1:0] acc_c;
  logic            is_cont;

  // Results of the byte itself (m0, m1) and of the string end (x).
  logic            m0_on, m1_on, x_on;
  logic [CP_W-1:0] m0_cp, m1_cp;
  logic            m0_vld, m0_err, m1_vld, m1_err, x_err;
  logic            err_any, ok_after;
  res_t            s0, s1;
  logic            s0_on, s1_on;

  assign accept  = in_valid && !q_full;
  assign lead    = lead_decode(in_byte_in);
  assign k       = {1'b0, rcv_r} + 3'd1;
  assign n3      = {1'b0, exp_r};
  assign acc_c   = {acc_r[CP_W-7:0], in_byte_in[5:0]};
  assign is_cont = (in_byte_in & CONT_MASK) == CONT_PAT;

  // Sequence state update for one byte.
  always_comb begin
    exp_nxt  = exp_r;
    rcv_nxt  = rcv_r;
    skip_nxt = skip_r;
    acc_nxt  = acc_r;
    m0_on = 1'b0; m0_cp = '0; m0_vld = 1'b0; m0_err = 1'b0;
    m1_on = 1'b0; m1_cp = '0; m1_vld = 1'b0; m1_err = 1'b0;
    x_on  = 1'b0; x_err = 1'b0;
    if (!mode_r) begin
      exp_nxt  = '0;
      rcv_nxt  = '0;
      skip_nxt = '0;
      acc_nxt  = '0;
      m0_on    = 1'b1;
      m0_cp    = CP_W'(in_byte_in);
      m0_vld   = 1'b1;
    end else if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (exp_r != 2'd0) begin
      if (is_cont) begin
        if (k >= n3) begin
          m0_on   = 1'b1;
          m0_cp   = acc_c;
          m0_vld  = 1'b1;
          exp_nxt = '0;
          rcv_nxt = '0;
          acc_nxt = '0;
        end else begin
          rcv_nxt = k[1:0];
          acc_nxt = acc_c;
        end
      end else begin
        // Bad continuation: error, then resume at lead plus expected count.
        m0_on   = 1'b1;
        m0_err  = 1'b1;
        exp_nxt = '0;
        rcv_nxt = '0;
        acc_nxt = '0;
        if (k >= n3) begin
          if (lead.emit) begin
            m1_on  = 1'b1;
            m1_cp  = lead.cp;
            m1_vld = lead.vld;
            m1_err = lead.err;
          end else begin
            exp_nxt = lead.exp;
            acc_nxt = lead.acc;
          end
        end else begin
          skip_nxt = 2'(n3 - k - 3'd1);
        end
      end
    end else begin
      if (lead.emit) begin
        m0_on  = 1'b1;
        m0_cp  = lead.cp;
        m0_vld = lead.vld;
        m0_err = lead.err;
      end else begin
        exp_nxt = lead.exp;
        rcv_nxt = '0;
        acc_nxt = lead.acc;
      end
    end

    // End of string: truncation error or an empty closing result.
    if (in_end_of_string) begin
      if (exp_nxt != 2'd0) begin
        x_on  = 1'b1;
        x_err = 1'b1;
      end else if (!m0_on) begin
        x_on = 1'b1;
      end
      exp_nxt  = '0;
      rcv_nxt  = '0;
      skip_nxt = '0;
      acc_nxt  = '0;
    end
  end

  assign err_any  = (m0_on && m0_err) || (m1_on && m1_err) || (x_on && x_err);
  assign ok_after = ok_r && !err_any;
  assign ok_nxt   = in_end_of_string ? 1'b1 : ok_after;

  // Pack results into slots and mark the last one.
  always_comb begin
    s0 = '0;
    s1 = '0;
    s0_on = 1'b0;
    s1_on = 1'b0;
    if (m0_on) begin
      s0_on = 1'b1;
      s0.code_point = m0_vld ? m0_cp : '0;
      s0.code_valid = m0_vld;
      s0.is_error   = m0_err;
      if (m1_on) begin
        s1_on = 1'b1;
        s1.code_point = m1_vld ? m1_cp : '0;
        s1.code_valid = m1_vld;
        s1.is_error   = m1_err;
      end else if (x_on) begin
        s1_on = 1'b1;
        s1.is_error = x_err;
      end
    end else if (x_on) begin
      s0_on = 1'b1;
      s0.is_error = x_err;
    end
    if (s1_on) begin
      s1.run_last     = 1'b1;
      s1.string_end   = in_end_of_string;
      s1.string_valid = in_end_of_string && ok_after;
    end else if (s0_on) begin
      s0.run_last     = 1'b1;
      s0.string_end   = in_end_of_string;
      s0.string_valid = in_end_of_string && ok_after;
    end
  end

  assign q_push      = accept && s0_on;
  assign q_wdata.r0  = s0;
  assign q_wdata.r1  = s1;
  assign q_wdata.two = s1_on;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_utf8_mode;
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      rcv_r  <= '0;
      skip_r <= '0;
      acc_r  <= '0;
      ok_r   <= 1'b1;
    end else if (accept) begin
      exp_r  <= exp_nxt;
      rcv_r  <= rcv_nxt;
      skip_r <= skip_nxt;
      acc_r  <= acc_nxt;
      ok_r   <= ok_nxt;
    end
  end

  // A skip never overlaps a pending sequence.
  a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != 2'd0) |-> (exp_r == 2'd0))
    else $error("skip pending while a sequence is open");

  // The received count stays below the expected count.
  a_rcv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != 2'd0) |-> (rcv_r < exp_r))
    else $error("received count reached expected count");

  // The end of a string leaves a clean state.
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_string) |=> (exp_r == 2'd0 && skip_r == 2'd0 && ok_r))
    else $error("state not cleared after string end");

endmodule

### rtl/utf8d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_fifo
// Short queue of per-byte result entries between the decode front and the
// output back.
// ----------------------------------------------------------------------------
module utf8d_fifo #(
  parameter int DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8d_pkg::evt_t wdata,
  input  logic            pop,
  output utf8d_pkg::evt_t rdata,
  output logic            full,
  output logic            empty
);
  import utf8d_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  evt_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

### rtl/utf8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// Unpacks queue entries into single result items and holds each in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  utf8d_pkg::evt_t head,
  input  logic            empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output utf8d_pkg::res_t out_res
);
  import utf8d_pkg::*;

  logic out_valid_r;
  res_t out_r;
  logic sel_r, sel_nxt;
  logic load;

  assign load    = !out_valid_r || !out_stall;
  assign pop     = load && !empty && (sel_r || !head.two);
  assign sel_nxt = (load && !empty) ? (!sel_r && head.two) : sel_r;

  // Output register and slot select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        out_valid_r <= !empty;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_r <= sel_r ? head.r1 : head.r0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // The second slot is only selected on a two-result entry at the head.
  a_sel_head: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!empty && head.two))
    else $error("second slot selected without a two-result entry");

  // An entry leaves the queue only when the output register takes a result.
  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (load && !empty))
    else $error("entry dropped without a result load");

  // A shown result that is not the last of its byte has its partner pending.
  a_partner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.run_last) |-> sel_r)
    else $error("first result shown without its partner pending");

endmodule

### rtl/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// The decoder accepts one byte per clock whenever its result queue has room
// and turns it into zero, one or two result items; a byte that gives no
// result still closes its string with one result when end_of_string is set.
// Results leave through a registered output at one item per clock while
// out_stall is low, so a byte with two results (an error followed by a
// retaken lead, or a truncation) holds the output port until both are
// taken; a byte's results are written into the queue and then loaded into
// the output register. Input stalls only when the queue of QUEUE_DEPTH
// byte entries is full, which happens only while the output side is stalled
// or two-result bytes outpace the output port.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 to code point decoder with per-string validity report.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int QUEUE_DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_utf8_mode,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_in,
  input  logic                       in_end_of_string,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [utf8d_pkg::CP_W-1:0] out_code_point,
  output logic                       out_code_valid,
  output logic                       out_is_error,
  output logic                       out_run_last,
  output logic                       out_string_end,
  output logic                       out_string_valid
);
  import utf8d_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  evt_t q_wdata, q_rdata;
  res_t res;

  assign in_stall = q_full;

  // Decode front.
  utf8d_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_utf8_mode    (cfg_utf8_mode),
    .in_valid         (in_valid),
    .in_byte_in       (in_byte_in),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  // Queue between front and back.
  utf8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Output back.
  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rdata),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_code_point   = res.code_point;
  assign out_code_valid   = res.code_valid;
  assign out_is_error     = res.is_error;
  assign out_run_last     = res.run_last;
  assign out_string_end   = res.string_end;
  assign out_string_valid = res.string_valid;

endmodule
